/* rtl/pbnf_pkg.sv */
`default_nettype none

package pbnf_pkg;

    localparam int PAGE_W    = 12;
    localparam int COUNT_W   = 13;
    localparam int WORD_BITS = 32;
    localparam int OFF_BITS  = 5;
    localparam int PWORD_W   = PAGE_W - OFF_BITS;

    localparam logic [PAGE_W-1:0]  LOW_PAGES = PAGE_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(8191);
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(256);

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;
    localparam logic [1:0] OP_MARK    = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PAGE_W-1:0] page;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0]  result_page;
        logic               found;
        logic [COUNT_W-1:0] used_pages;
        logic [COUNT_W-1:0] total_pages;
    } t_rsp;

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + COUNT_W'(1) : COUNT_MAX;
    endfunction

    function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] c);
        return (c != '0) ? c - COUNT_W'(1) : '0;
    endfunction

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [OFF_BITS-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [OFF_BITS-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = OFF_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/page_bitmap_next_fit_allocator.sv */
`default_nettype none

// Channel  Direction  Handshake                    Payload
// -------  ---------  ---------------------------  -------------------------
// in       input      i_in_valid / o_in_ready      i_in_data  (opcode, page)
// out      output     o_out_valid / i_out_ready    o_out_data (result_page,
//                                                  found, used/total pages)
//
// After reset the bitmap memory is cleared one 32-page word per cycle:
// ceil(min(PAGES,4096)/32) words (128 by default) with o_in_ready low.
// Free, reserve and mark usable go through read, modify and write, then result; ignored ones go straight to result.
// Allocate reads one bitmap word per scan step, at most 120 words by default,
// since the scan never starts below word 8; the single read port paces the scan.
// A full output register holds the block in its result step until the word is taken.

module page_bitmap_next_fit_allocator #(
    parameter int PAGES = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  pbnf_pkg::t_req     i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pbnf_pkg::t_rsp     o_out_data
);

    import pbnf_pkg::*;

    localparam int MAP_DEPTH = (PAGES < (1 << PAGE_W)) ? PAGES : (1 << PAGE_W);
    localparam int WORDS     = (MAP_DEPTH + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = $clog2(WORDS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_word, n_word;
    logic [OFF_BITS-1:0] r_off, n_off;
    logic [1:0]          r_op, n_op;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [PAGE_W-1:0]   r_cursor, n_cursor;
    logic [PAGE_W-1:0]   r_top, n_top;
    logic [COUNT_W-1:0]  r_used, n_used;
    logic [COUNT_W-1:0]  r_total, n_total;
    logic [PAGE_W-1:0]   r_res_page, n_res_page;
    logic                r_found, n_found;
    logic                r_ov, n_ov;
    t_rsp                r_out, n_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [2*WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [2*WORD_BITS-1:0] ram_rdata;

    // Word layout: usable bits in the upper half, used bits in the lower half.
    logic [WORD_BITS-1:0] rd_used, rd_usable, cand;
    logic [OFF_BITS-1:0]  hit_bit;
    logic [PWORD_W-1:0]   in_pword, top_pword, hit_pword;
    logic [AW-1:0]        top_word;
    logic [COUNT_W-1:0]   start13;
    logic [PAGE_W-1:0]    start;
    logic                 in_range;

    pbnf_ram #(
        .WIDTH(2 * WORD_BITS),
        .DEPTH(WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_used   = ram_rdata[WORD_BITS-1:0];
    assign rd_usable = ram_rdata[2*WORD_BITS-1:WORD_BITS];
    assign cand      = rd_usable & ~rd_used & ({WORD_BITS{1'b1}} << r_off);
    assign hit_bit   = first_set(cand);
    assign hit_pword = PWORD_W'(r_word);
    assign in_pword  = i_in_data.page[PAGE_W-1:OFF_BITS];
    assign top_pword = r_top[PAGE_W-1:OFF_BITS];
    assign top_word  = top_pword[AW-1:0];
    assign in_range  = (PAGES >= (1 << PAGE_W)) || (int'(i_in_data.page) < PAGES);

    // Next-fit start page: one past the cursor, back to the first page
    // above low memory when it leaves the usable range.
    always_comb begin
        start13 = {1'b0, r_cursor} + COUNT_W'(1);
        if (start13 < {1'b0, LOW_PAGES} || start13 > {1'b0, r_top}) begin
            start13 = {1'b0, LOW_PAGES};
        end
        start = start13[PAGE_W-1:0];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_word     = r_word;
        n_off      = r_off;
        n_op       = r_op;
        n_page     = r_page;
        n_cursor   = r_cursor;
        n_top      = r_top;
        n_used     = r_used;
        n_total    = r_total;
        n_res_page = r_res_page;
        n_found    = r_found;
        n_ov       = r_ov & ~i_out_ready;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_word;
        ram_wdata  = ram_rdata;
        ram_raddr  = r_word;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_word    = r_word + AW'(1);
                if (r_word == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = in_pword[AW-1:0];
                if (i_in_valid) begin
                    n_op       = i_in_data.opcode;
                    n_page     = i_in_data.page;
                    n_res_page = '0;
                    n_found    = 1'b0;
                    n_state    = S_OUT;
                    if (i_in_data.opcode == OP_ALLOC) begin
                        ram_raddr = start[OFF_BITS +: AW];
                        if (r_used < r_total) begin
                            if (start <= r_top) begin
                                n_word  = start[OFF_BITS +: AW];
                                n_off   = start[OFF_BITS-1:0];
                                n_state = S_SCAN;
                            end else begin
                                n_cursor = r_top + PAGE_W'(1);
                            end
                        end else begin
                            n_cursor = start;
                        end
                    end else if (in_range &&
                                 (i_in_data.opcode != OP_MARK ||
                                  i_in_data.page >= LOW_PAGES)) begin
                        n_word  = in_pword[AW-1:0];
                        n_state = S_MOD;
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = r_word + AW'(1);
                n_off     = '0;
                if (cand != '0) begin
                    ram_we                      = 1'b1;
                    ram_wdata[{1'b0, hit_bit}]  = 1'b1;
                    n_used                      = count_up(r_used);
                    n_res_page                  = {hit_pword, hit_bit};
                    n_found                     = 1'b1;
                    n_cursor                    = {hit_pword, hit_bit};
                    n_state                     = S_OUT;
                end else if (r_word == top_word) begin
                    n_cursor = r_top + PAGE_W'(1);
                    n_state  = S_OUT;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            S_MOD: begin
                ram_we  = 1'b1;
                n_state = S_OUT;
                case (r_op)
                    OP_FREE: begin
                        ram_wdata[{1'b0, r_page[OFF_BITS-1:0]}] = 1'b0;
                        n_used = count_down(r_used);
                    end
                    OP_RESERVE: begin
                        ram_wdata[{1'b0, r_page[OFF_BITS-1:0]}] = 1'b1;
                        n_used = count_up(r_used);
                    end
                    default: begin
                        // Mark usable; a page that is already usable changes nothing.
                        if (!rd_usable[r_page[OFF_BITS-1:0]]) begin
                            ram_wdata[{1'b1, r_page[OFF_BITS-1:0]}] = 1'b1;
                            n_total = count_up(r_total);
                            if (r_page > r_top) begin
                                n_top = r_page;
                            end
                        end
                    end
                endcase
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov              = 1'b1;
                    n_out.result_page = r_res_page;
                    n_out.found       = r_found;
                    n_out.used_pages  = r_used;
                    n_out.total_pages = r_total;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_word   <= '0;
            r_off    <= '0;
            r_cursor <= '0;
            r_top    <= '0;
            r_used   <= COUNT_RST;
            r_total  <= COUNT_RST;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_word   <= n_word;
            r_off    <= n_off;
            r_cursor <= n_cursor;
            r_top    <= n_top;
            r_used   <= n_used;
            r_total  <= n_total;
            r_ov     <= n_ov;
        end
        r_op       <= n_op;
        r_page     <= n_page;
        r_res_page <= n_res_page;
        r_found    <= n_found;
        r_out      <= n_out;
    end

`ifndef SYNTHESIS
    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while one is in progress");

    a_grant_above_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> (o_out_data.result_page >= LOW_PAGES))
        else $error("granted page lies in low memory");

    a_miss_zero_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.result_page == '0))
        else $error("nonzero page on a miss");

    a_top_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_top) < MAP_DEPTH)
        else $error("top usable page outside the bitmap");

    a_grant_within_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && cand != '0) |-> ({hit_pword, hit_bit} <= r_top))
        else $error("scan found a page above the top usable page");
`endif

endmodule

`default_nettype wire

/* rtl/pbnf_ram.sv */
`default_nettype none

module pbnf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
